/* src/sdf_pkg.sv */
// Shared constants and types for the signed decimal formatter.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned PREC_W        = 6;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned MAX_PRECISION = 63;

  // 20 BCD digits cover any 64-bit magnitude
  localparam int unsigned DIGIT_SLOTS = 20;
  localparam int unsigned BCD_W       = 4 * DIGIT_SLOTS;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;

endpackage

/* src/sdf_in_if.sv */
// Input channel of the signed decimal formatter: valid/ready plus payload.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

interface sdf_in_if
  import sdf_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic        [PREC_W-1:0]  precision;
  logic                      plus_sign;

  modport source (output valid, output value, output precision, output plus_sign,
                  input ready);
  modport sink   (input valid, input value, input precision, input plus_sign,
                  output ready);
endinterface

/* src/sdf_out_if.sv */
// Output channel of the signed decimal formatter: one character per transaction.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

interface sdf_out_if
  import sdf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* src/signed_decimal_formatter.sv */
// Signed decimal formatter top level: binary to BCD conversion and character emission.
// Depends on sdf_pkg, sdf_in_if and sdf_out_if.
//
// Usage:
//   in_i  carries one transaction per number: value (signed 64 bit), precision
//         (minimum digit count, saturated to MaxPrecision) and plus_sign.
//   out_o carries the text, one ASCII character per transaction: an optional
//         sign ('-' for negative values, '+' when plus_sign is set), zero padding
//         up to the precision, then the digits; last_char marks the final one.
//   Sequence: after a value is taken, the magnitude is shifted into a BCD
//   register one bit per cycle (shift-and-add-3), then leading zero digits
//   are dropped one digit per cycle, then one character leaves per cycle
//   while out_o.ready is high. in_i.ready is high again once the last
//   character is loaded into the output register, so the next number starts
//   while it still waits.
//   Stall: when out_o.ready is low the output register holds its character and
//   emission pauses; nothing is dropped.
//   Reset: rst_ni low clears the state machine and the output valid flag.
`timescale 1ns / 1ps

module signed_decimal_formatter
  import sdf_pkg::*;
#(
  parameter int unsigned MaxPrecision = MAX_PRECISION
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sdf_in_if.sink           in_i,
  sdf_out_if.source        out_o
);

  localparam int unsigned PadW = $clog2(MaxPrecision + 1);
  localparam int unsigned DigW = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned BitW = $clog2(VALUE_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIGN,
    ST_PAD,
    ST_DIGIT
  } state_e;

  state_e             state_q;
  logic [VALUE_W-1:0] mag_q;
  logic [BCD_W-1:0]   bcd_q;
  logic [BitW-1:0]    bit_cnt_q;
  logic [DigW-1:0]    dig_cnt_q;
  logic [PadW-1:0]    prec_q;
  logic [PadW-1:0]    pad_q;
  logic               neg_q;
  logic               has_sign_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic               last_q;

  logic               in_fire;
  logic               slot_free;
  logic               char_load;
  logic [VALUE_W-1:0] mag_in;
  logic [PadW-1:0]    prec_sat;
  logic [BCD_W-1:0]   bcd_adj;
  logic [3:0]         top_digit;
  logic [PadW-1:0]    dig_ext;
  logic [PadW-1:0]    pad_calc;
  logic               norm_done;

  assign in_i.ready      = (state_q == ST_IDLE);
  assign in_fire         = in_i.valid && in_i.ready;
  assign slot_free       = !out_valid_q || out_o.ready;
  // a character enters the output register in every emitting state with room
  assign char_load       = slot_free && (state_q inside {ST_SIGN, ST_PAD, ST_DIGIT});

  assign out_o.valid     = out_valid_q;
  assign out_o.char_code = char_q;
  assign out_o.last_char = last_q;

  // Two's complement magnitude; the most negative value wraps to 2^63 unsigned.
  assign mag_in   = in_i.value[VALUE_W-1] ? (~in_i.value + VALUE_W'(1)) : in_i.value;
  assign prec_sat = (PREC_W'(in_i.precision) > PREC_W'(MaxPrecision))
                    ? PadW'(MaxPrecision) : PadW'(in_i.precision);

  // Add-3 correction on every BCD digit before each shift.
  always_comb begin
    for (int d = 0; d < DIGIT_SLOTS; d++) begin
      if (bcd_q[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
      end
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign norm_done = (top_digit != 4'd0) || (dig_cnt_q == DigW'(1));
  assign dig_ext   = PadW'(dig_cnt_q);
  assign pad_calc  = (prec_q > dig_ext) ? (prec_q - dig_ext) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      bcd_q       <= '0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      prec_q      <= '0;
      pad_q       <= '0;
      neg_q       <= 1'b0;
      has_sign_q  <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      // raise the valid flag on a new character, drop it once the receiver
      // takes the last one
      if (char_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            mag_q      <= mag_in;
            bcd_q      <= '0;
            bit_cnt_q  <= '0;
            prec_q     <= prec_sat;
            neg_q      <= in_i.value[VALUE_W-1];
            has_sign_q <= in_i.value[VALUE_W-1] || in_i.plus_sign;
            state_q    <= ST_CONV;
          end
        end

        ST_CONV: begin
          // shift one magnitude bit, MSB first, into the corrected BCD register
          bcd_q     <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
          mag_q     <= {mag_q[VALUE_W-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q + BitW'(1);
          if (bit_cnt_q == BitW'(VALUE_W - 1)) begin
            dig_cnt_q <= DigW'(DIGIT_SLOTS);
            state_q   <= ST_NORM;
          end
        end

        ST_NORM: begin
          // drop leading zero digits, but always keep one
          if (norm_done) begin
            pad_q <= pad_calc;
            if (has_sign_q) begin
              state_q <= ST_SIGN;
            end else if (pad_calc != '0) begin
              state_q <= ST_PAD;
            end else begin
              state_q <= ST_DIGIT;
            end
          end else begin
            bcd_q     <= {bcd_q[BCD_W-5:0], 4'd0};
            dig_cnt_q <= dig_cnt_q - DigW'(1);
          end
        end

        ST_SIGN: begin
          if (slot_free) begin
            char_q      <= neg_q ? CH_MINUS : CH_PLUS;
            last_q      <= 1'b0;
            state_q     <= (pad_q != '0) ? ST_PAD : ST_DIGIT;
          end
        end

        ST_PAD: begin
          if (slot_free) begin
            char_q      <= CH_ZERO;
            last_q      <= 1'b0;
            pad_q       <= pad_q - PadW'(1);
            if (pad_q == PadW'(1)) begin
              state_q <= ST_DIGIT;
            end
          end
        end

        ST_DIGIT: begin
          if (slot_free) begin
            char_q      <= CH_ZERO + CHAR_W'(top_digit);
            last_q      <= (dig_cnt_q == DigW'(1));
            bcd_q       <= {bcd_q[BCD_W-5:0], 4'd0};
            dig_cnt_q   <= dig_cnt_q - DigW'(1);
            if (dig_cnt_q == DigW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A taken number always starts the conversion sweep.
  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_CONV))
    else $error("accepted number did not start conversion");

  // Digit emission never runs with an empty digit count.
  a_digit_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (dig_cnt_q != '0))
    else $error("digit emission with zero digits left");

  // A waiting character that is not final belongs to a text still being emitted.
  a_mid_text_char_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> ((state_q == ST_PAD) || (state_q == ST_DIGIT)))
    else $error("non-final character pending outside of text emission");

  // Conversion stays the full width of the magnitude.
  a_conv_to_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CONV) && (bit_cnt_q == BitW'(VALUE_W - 1))) |=>
      ((state_q == ST_NORM) && (dig_cnt_q == DigW'(DIGIT_SLOTS))))
    else $error("conversion did not hand over to normalization");

endmodule

/* tb/signed_decimal_formatter_test.sv */
// Self-checking testbench for signed_decimal_formatter: drives numbers into in_i,
// predicts the ASCII text of each one and checks every character on out_o.
// Depends on sdf_pkg, sdf_in_if, sdf_out_if and the formatter RTL.
`timescale 1ns / 1ps

module signed_decimal_formatter_test;
  import sdf_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  // Idle cycles tolerated with no transaction on either channel. The long
  // receiver hold-off below is far shorter than this limit.
  localparam int unsigned STALL_LIMIT   = 5000;
  // Cycles to watch the output after the last expected character has arrived.
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_OFF_LEN  = 600;
  localparam int unsigned MAX_REPORTS   = 40;

  // One character of an expected text.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic clk;
  logic rst_n;

  sdf_in_if  in_ch ();
  sdf_out_if out_ch ();

  signed_decimal_formatter u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Expected characters, oldest first, across all numbers in flight.
  text_char_t  expected_chars[$];

  int unsigned mismatch_count;
  int unsigned numbers_sent;
  int unsigned chars_checked;
  int unsigned full_texts;
  int unsigned negative_numbers;
  int unsigned signed_plus_numbers;

  // Idling control shared by the test tasks and the receiver process.
  bit          src_no_idle;
  bit          sink_no_idle;
  int unsigned sink_hold_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Report one mismatch: print a line for the first few, count all of them.
  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Queue one expected character.
  function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
    text_char_t c;
    c.code = code;
    c.last = last;
    expected_chars.push_back(c);
  endfunction

  // Predict the text of one number: optional sign, zero padding up to the
  // saturated precision, then every digit of the magnitude (at least one).
  function automatic void format_decimal(input logic [VALUE_W-1:0] raw,
                                         input logic [PREC_W-1:0]  prec_in,
                                         input logic               plus);
    logic [3:0]         digit_buf [DIGIT_SLOTS];
    logic [VALUE_W-1:0] mag;
    logic               neg;
    logic               has_sign;
    int unsigned        ndig;
    int unsigned        prec;
    int unsigned        pad;
    int unsigned        total;
    int unsigned        idx;

    neg = raw[VALUE_W-1];
    // The most negative value wraps onto itself, read unsigned as 2^63.
    mag = neg ? (~raw + 1'b1) : raw;
    ndig = 0;
    do begin
      digit_buf[ndig] = 4'(mag % 10);
      mag = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < DIGIT_SLOTS);

    prec = (prec_in > MAX_PRECISION) ? MAX_PRECISION : prec_in;
    pad = (prec > ndig) ? prec - ndig : 0;
    has_sign = neg | plus;
    total = (has_sign ? 1 : 0) + pad + ndig;

    idx = 0;
    if (has_sign) begin
      push_char(neg ? CH_MINUS : CH_PLUS, idx + 1 == total);
      idx++;
    end
    repeat (pad) begin
      push_char(CH_ZERO, idx + 1 == total);
      idx++;
    end
    for (int i = int'(ndig) - 1; i >= 0; i--) begin
      push_char(CH_ZERO + 8'(digit_buf[i]), idx + 1 == total);
      idx++;
    end

    if (total == 64) full_texts++;
    if (neg) negative_numbers++;
    else if (plus) signed_plus_numbers++;
  endfunction

  // Offer one number and hold it until the block takes it. Valid stays high
  // afterwards so a following number can go out back to back; release_input
  // drops it when the sender stops.
  task automatic send_number(input logic [VALUE_W-1:0] raw,
                             input logic [PREC_W-1:0]  prec,
                             input logic               plus);
    int unsigned gap;
    gap = src_no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= raw;
    in_ch.precision <= prec;
    in_ch.plus_sign <= plus;
    do @(posedge clk); while (!in_ch.ready);
    format_decimal(raw, prec, plus);
    numbers_sent++;
  endtask

  // Drop valid and let the clock advance so no later send touches it in this step.
  task automatic release_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every predicted character has been seen.
  task automatic wait_for_drain();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Draw a value: full-range noise, small numbers, neighbors of powers of ten,
  // 32-bit values and values near the two extremes, with either sign.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p10;
    int unsigned        kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: v = {$urandom, $urandom};
      3, 4: v = 64'($urandom_range(0, 999));
      5: begin
        p10 = 64'd1;
        repeat ($urandom_range(0, 18)) p10 = p10 * 10;
        v = p10 + 64'($urandom_range(0, 2)) - 64'd1;
      end
      6: v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      7: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
      8: v = {32'd0, $urandom};
      default: v = 64'($urandom_range(0, 99));
    endcase
    if (kind inside {[3:5], [8:9]} && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Mostly modest precision keeps texts short; some reach the full 63.
  function automatic logic [PREC_W-1:0] pick_precision();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind <= 6) return PREC_W'($urandom_range(0, 22));
    if (kind <= 8) return PREC_W'($urandom_range(0, 63));
    return PREC_W'(MAX_PRECISION);
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_number(pick_value(), pick_precision(), 1'($urandom_range(0, 1)));
  endtask

  // Zero, the extremes, sign rules, padding above, at and below the digit
  // count, and the longest possible texts.
  task automatic test_directed();
    send_number(64'd0, 6'd0, 1'b0);
    send_number(64'd0, 6'd0, 1'b1);
    send_number(64'd0, 6'd5, 1'b0);
    send_number(64'd0, 6'd63, 1'b1);
    send_number(64'd1, 6'd0, 1'b0);
    send_number('1, 6'd0, 1'b0);
    send_number('1, 6'd63, 1'b0);
    send_number('1, 6'd3, 1'b1);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 6'd0, 1'b0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 6'd19, 1'b1);
    send_number(64'h8000_0000_0000_0000, 6'd0, 1'b0);
    send_number(64'h8000_0000_0000_0000, 6'd18, 1'b1);
    send_number(64'h8000_0000_0000_0000, 6'd63, 1'b0);
    send_number(64'd9, 6'd1, 1'b0);
    send_number(64'd10, 6'd2, 1'b1);
    send_number(64'd99, 6'd1, 1'b0);
    send_number(64'd100, 6'd4, 1'b0);
    send_number(64'd12345, 6'd20, 1'b1);
    send_number(64'd999999999999999999, 6'd0, 1'b1);
    send_number(64'd1000000000000000000, 6'd0, 1'b0);
    send_number(-64'd1000000000000000000, 6'd21, 1'b0);
    send_number(64'h5555_5555_5555_5555, 6'd42, 1'b1);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, 6'd42, 1'b0);
    send_number(64'd7, 6'd2, 1'b0);
    release_input();
  endtask

  // Both sides keep their handshakes open every cycle.
  task automatic test_back_to_back();
    src_no_idle  = 1'b1;
    sink_no_idle = 1'b1;
    send_random(40);
    release_input();
    wait_for_drain();
    src_no_idle  = 1'b0;
    sink_no_idle = 1'b0;
  endtask

  // Hold off the receiver for a long stretch while numbers keep coming, so
  // the output register and the converter fill and in_i.ready drops.
  task automatic test_output_hold_off();
    sink_hold_cycles = HOLD_OFF_LEN;
    src_no_idle = 1'b1;
    send_random(8);
    src_no_idle = 1'b0;
    release_input();
  endtask

  // Pause the sender until every expected character has come back.
  task automatic test_drain_pause();
    send_random(10);
    release_input();
    wait_for_drain();
    send_random(10);
    release_input();
  endtask

  // Receiver: after each character draw a random stall, none while sink_no_idle
  // is set; the long hold-off counts down here and overrides everything else.
  initial begin : sink_ctrl
    int unsigned stall_left;
    out_ch.ready = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        sink_hold_cycles--;
      end else if (out_ch.valid && out_ch.ready) begin
        stall_left = sink_no_idle ? 0 : $urandom_range(0, 9);
        out_ch.ready <= (stall_left == 0);
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= (stall_left == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Check each output transaction against the oldest expected character.
  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                  out_ch.char_code, out_ch.last_char));
      end else begin
        exp_c = expected_chars.pop_front();
        chars_checked++;
        if (out_ch.char_code !== exp_c.code) begin
          report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
                                    out_ch.char_code, exp_c.code));
        end
        if (out_ch.last_char !== exp_c.last) begin
          report_mismatch($sformatf("last_char %0b, expected %0b (char 0x%02h)",
                                    out_ch.last_char, exp_c.last, exp_c.code));
        end
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    int unsigned quiet_cycles;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles, %0d characters pending",
                 $realtime, STALL_LIMIT, expected_chars.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.value      = '0;
    in_ch.precision  = '0;
    in_ch.plus_sign  = 1'b0;
    rst_n            = 1'b0;
    mismatch_count   = 0;
    numbers_sent     = 0;
    chars_checked    = 0;
    full_texts       = 0;
    negative_numbers = 0;
    signed_plus_numbers = 0;
    src_no_idle      = 1'b0;
    sink_no_idle     = 1'b0;
    sink_hold_cycles = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    send_random(300);
    release_input();
    test_back_to_back();
    test_output_hold_off();
    test_drain_pause();
    send_random(50);
    release_input();

    // Let the last text finish, then watch for stray characters.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      report_mismatch($sformatf("%0d expected characters never arrived",
                                expected_chars.size()));
    end

    $display("Formatted %0d numbers (%0d negative, %0d with forced plus), %0d characters checked.",
             numbers_sent, negative_numbers, signed_plus_numbers, chars_checked);
    $display("Texts of the maximum 64 characters: %0d; mismatches: %0d.",
             full_texts, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
src/sdf_pkg.sv
src/sdf_in_if.sv
src/sdf_out_if.sv
src/signed_decimal_formatter.sv
tb/signed_decimal_formatter_test.sv
